// ===== rtl/core/split_join_distance_defines.svh =====
// ----------------------------------------------------------------------------
// Split-join distance: assertion macros
// Shared property templates for the checker, clocked on clk_i and
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SPLIT_JOIN_DISTANCE_DEFINES_SVH
`define SPLIT_JOIN_DISTANCE_DEFINES_SVH

// condition must never hold
`define SJD_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

// same-cycle implication
`define SJD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SJD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sjd_pkg.sv =====
// ----------------------------------------------------------------------------
// Split-join distance package
// Controller states, command and status bundles, fixed field widths.
// ----------------------------------------------------------------------------
package sjd_pkg;

  // width of the incoming label fields
  localparam int unsigned LABEL_W = 6;
  // number of distinct raw label codes
  localparam int unsigned LABEL_CODES = 1 << LABEL_W;
  // width of counts, sums and distances
  localparam int unsigned CNT_W = 16;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_EMIT
  } sjd_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;       // input beat taken: capture labels and last
    logic ovf_set;    // beat taken while the count is full
    logic update;     // read-modify-write of the tables
    logic sweep;      // clearing pass: write zero, advance sweep address
    logic clr_scalar; // result taken: clear sums, count and flag
  } sjd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;       // item count at its limit
    logic last;       // captured last marker
    logic sweep_done; // sweep address at its final entry
  } sjd_sts_t;

endpackage

// ===== rtl/core/sjd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sjd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/sjd_datapath.sv =====
// ----------------------------------------------------------------------------
// Split-join distance datapath
// Pair-count, row-maximum and column-maximum tables, running sums,
// element count, overflow flag and clearing sweep counter.
// ----------------------------------------------------------------------------
module sjd_datapath
  import sjd_pkg::*;
#(
  parameter int unsigned LABELS    = 64,
  parameter int unsigned MAX_ITEMS = 65535
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [LABEL_W-1:0] label_a_i,
  input  logic [LABEL_W-1:0] label_b_i,
  input  logic               last_i,
  input  sjd_cmd_t           cmd_i,
  output sjd_sts_t           sts_o,
  output logic [CNT_W-1:0]   dist_ab_o,
  output logic [CNT_W-1:0]   dist_ba_o,
  output logic [CNT_W-1:0]   element_total_o,
  output logic               overflow_o
);

  localparam int unsigned LBW        = $clog2(LABELS);
  localparam int unsigned PAW        = 2 * LBW;
  localparam int unsigned PAIR_DEPTH = 1 << PAW;
  localparam int unsigned CNT_MAX    = (1 << CNT_W) - 1;
  localparam logic [CNT_W-1:0] LIMIT =
    (MAX_ITEMS < CNT_MAX) ? CNT_W'(MAX_ITEMS) : CNT_W'(CNT_MAX);

  // label reduction table: raw code modulo LABELS, worked out at elaboration
  logic [LBW-1:0] lbl_mod [LABEL_CODES];

  for (genvar g = 0; g < LABEL_CODES; g++) begin : g_lbl_mod
    assign lbl_mod[g] = LBW'(g % LABELS);
  end

  logic [LBW-1:0]   a_in, b_in;
  logic [LBW-1:0]   a_q, b_q;
  logic             last_q;
  logic [PAW-1:0]   sweep_q, sweep_d;
  logic [CNT_W-1:0] row_sum_q, row_sum_d;
  logic [CNT_W-1:0] col_sum_q, col_sum_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             ovf_q, ovf_d;

  logic [CNT_W-1:0] pair_rd, row_rd, col_rd;
  logic [CNT_W-1:0] pair_nxt;
  logic             row_grow, col_grow;

  logic             pair_we, row_we, col_we;
  logic [PAW-1:0]   pair_waddr;
  logic [LBW-1:0]   row_waddr, col_waddr;
  logic [CNT_W-1:0] pair_wdata;

  assign a_in = lbl_mod[label_a_i];
  assign b_in = lbl_mod[label_b_i];

  // captured beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q    <= a_in;
      b_q    <= b_in;
      last_q <= last_i;
    end
  end

  // incremented pair count and the maxima it beats
  assign pair_nxt = pair_rd + CNT_W'(1);
  assign row_grow = pair_nxt > row_rd;
  assign col_grow = pair_nxt > col_rd;

  // table write side: sweep writes zero, update writes the new counts
  always_comb begin
    pair_we    = cmd_i.sweep | cmd_i.update;
    row_we     = cmd_i.sweep | (cmd_i.update & row_grow);
    col_we     = cmd_i.sweep | (cmd_i.update & col_grow);
    pair_waddr = cmd_i.sweep ? sweep_q : {a_q, b_q};
    row_waddr  = cmd_i.sweep ? sweep_q[LBW-1:0] : a_q;
    col_waddr  = cmd_i.sweep ? sweep_q[LBW-1:0] : b_q;
    pair_wdata = cmd_i.sweep ? '0 : pair_nxt;
  end

  sjd_ram #(.WIDTH(CNT_W), .DEPTH(PAIR_DEPTH)) u_pair_ram (
    .clk_i  (clk_i),
    .we_i   (pair_we),
    .waddr_i(pair_waddr),
    .wdata_i(pair_wdata),
    .raddr_i({a_in, b_in}),
    .rdata_o(pair_rd)
  );

  sjd_ram #(.WIDTH(CNT_W), .DEPTH(LABELS)) u_row_ram (
    .clk_i  (clk_i),
    .we_i   (row_we),
    .waddr_i(row_waddr),
    .wdata_i(pair_wdata),
    .raddr_i(a_in),
    .rdata_o(row_rd)
  );

  sjd_ram #(.WIDTH(CNT_W), .DEPTH(LABELS)) u_col_ram (
    .clk_i  (clk_i),
    .we_i   (col_we),
    .waddr_i(col_waddr),
    .wdata_i(pair_wdata),
    .raddr_i(b_in),
    .rdata_o(col_rd)
  );

  // scalar state
  always_comb begin
    sweep_d   = sweep_q;
    row_sum_d = row_sum_q;
    col_sum_d = col_sum_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    if (cmd_i.sweep) begin
      sweep_d = sweep_q + PAW'(1);
    end
    if (cmd_i.update) begin
      count_d = count_q + CNT_W'(1);
      if (row_grow) begin
        row_sum_d = row_sum_q + CNT_W'(1);
      end
      if (col_grow) begin
        col_sum_d = col_sum_q + CNT_W'(1);
      end
    end
    if (cmd_i.ovf_set) begin
      ovf_d = 1'b1;
    end
    if (cmd_i.clr_scalar) begin
      row_sum_d = '0;
      col_sum_d = '0;
      count_d   = '0;
      ovf_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q   <= '0;
      row_sum_q <= '0;
      col_sum_q <= '0;
      count_q   <= '0;
      ovf_q     <= 1'b0;
    end else begin
      sweep_q   <= sweep_d;
      row_sum_q <= row_sum_d;
      col_sum_q <= col_sum_d;
      count_q   <= count_d;
      ovf_q     <= ovf_d;
    end
  end

  // status
  assign sts_o.full       = count_q >= LIMIT;
  assign sts_o.last       = last_q;
  assign sts_o.sweep_done = &sweep_q;

  // result, held steady by the registers while it waits
  assign dist_ab_o       = count_q - row_sum_q;
  assign dist_ba_o       = count_q - col_sum_q;
  assign element_total_o = count_q;
  assign overflow_o      = ovf_q;

endmodule

// ===== rtl/core/sjd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Split-join distance controller
// Sequences clearing sweep, beat acceptance, table update and result beat.
// ----------------------------------------------------------------------------
module sjd_ctrl
  import sjd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     last_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  sjd_sts_t sts_i,
  output sjd_cmd_t cmd_o
);

  sjd_state_e state_q, state_d;
  logic       in_fire;

  assign in_fire = in_valid_i & (state_q == ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.sweep_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (!sts_i.full) begin
            state_d = ST_UPDATE;
          end else if (last_i) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_UPDATE: begin
        state_d = sts_i.last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          state_d = ST_CLEAR;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // outputs
  always_comb begin
    in_ready_o       = 1'b0;
    out_valid_o      = 1'b0;
    cmd_o            = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.sweep = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load    = in_fire;
        cmd_o.ovf_set = in_fire & sts_i.full;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
      end
      ST_EMIT: begin
        out_valid_o      = 1'b1;
        cmd_o.clr_scalar = out_ready_i;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== rtl/core/split_join_distance.sv =====
// ----------------------------------------------------------------------------
// Split-join distance accumulator
// A counted element is accepted in IDLE and then updates the tables in UPDATE;
// the result beat of a last element is raised after its table update, or straight
// after its accept when the count was already full. No new element is taken
// during a table update, owing to the read-modify-write of the pair-count memory.
// Reset, and every taken result, start a clearing pass over all
// 2**(2*clog2(LABELS)) pair-count entries (4096 by default) with input ready low.
// ----------------------------------------------------------------------------
module split_join_distance
  import sjd_pkg::*;
#(
  parameter int unsigned LABELS    = 64,
  parameter int unsigned MAX_ITEMS = 65535
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [LABEL_W-1:0] label_a_i,
  input  logic [LABEL_W-1:0] label_b_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CNT_W-1:0]   dist_ab_o,
  output logic [CNT_W-1:0]   dist_ba_o,
  output logic [CNT_W-1:0]   element_total_o,
  output logic               overflow_o
);

  sjd_cmd_t cmd;
  sjd_sts_t sts;

  sjd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .last_i     (last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sjd_datapath #(
    .LABELS   (LABELS),
    .MAX_ITEMS(MAX_ITEMS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .label_a_i      (label_a_i),
    .label_b_i      (label_b_i),
    .last_i         (last_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .dist_ab_o      (dist_ab_o),
    .dist_ba_o      (dist_ba_o),
    .element_total_o(element_total_o),
    .overflow_o     (overflow_o)
  );

endmodule

// ===== rtl/core/sjd_checker.sv =====
// ----------------------------------------------------------------------------
// Split-join distance port checker
// Watches the top-level ports for result sanity and sequencing.
// ----------------------------------------------------------------------------
`include "split_join_distance_defines.svh"

module sjd_checker
  import sjd_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [CNT_W-1:0] dist_ab_o,
  input logic [CNT_W-1:0] dist_ba_o,
  input logic [CNT_W-1:0] element_total_o,
  input logic             overflow_o
);

  logic out_take;
  logic out_stall;
  logic dist_ok;

  // result handshake terms
  assign out_take  = out_valid_o && out_ready_i;
  assign out_stall = out_valid_o && !out_ready_i;
  assign dist_ok   = (dist_ab_o < element_total_o) && (dist_ba_o < element_total_o);

  // one element at a time: no input taken while a result waits
  `SJD_ASSERT_NEVER(a_no_overlap, in_ready_o && out_valid_o, "ready while result pending")

  // a stalled result beat holds, overflow flag included
  `SJD_ASSERT_NXT(a_out_hold, out_stall, out_valid_o && $stable(overflow_o), "result moved")

  // a finished data set always holds at least one counted element
  `SJD_ASSERT_IMP(a_total_nonzero, out_valid_o, element_total_o != '0, "empty data set reported")

  // each distance stays below the element count
  `SJD_ASSERT_IMP(a_dist_bound, out_valid_o, dist_ok, "distance out of range")

  // a taken result starts the clearing pass
  `SJD_ASSERT_NXT(a_clear_after, out_take, !in_ready_o, "input ready during clear")

endmodule

bind split_join_distance sjd_checker u_sjd_checker (.*);
